// ----- rtl/p2z_pkg.sv -----
// p2z_pkg: types, constants and the slot hash shared by the page to zone map
// no dependencies
package p2z_pkg;

   localparam int TABLE_SLOTS  = 4096;
   localparam int SLOT_BITS    = $clog2(TABLE_SLOTS);
   localparam int RAM_DEPTH    = 2 * TABLE_SLOTS;
   localparam int RAM_ADDR_BITS = SLOT_BITS + 1;
   localparam int MAX_LIVE     = 3072;
   localparam int ADDR_BITS    = 48;
   localparam int ZONE_ID_BITS = 16;
   localparam int MODE_BITS    = 2;
   localparam int PAGES_BITS   = 13;
   localparam int SHIFT_BITS   = 5;
   localparam int MIN_SHIFT    = 12;
   localparam int MAX_SHIFT    = 16;
   localparam int FRAME_BITS   = ADDR_BITS - MIN_SHIFT;
   localparam int CNT_BITS     = $clog2(TABLE_SLOTS + 1);
   localparam int SUM_A        = (CNT_BITS > PAGES_BITS) ? CNT_BITS + 2 : PAGES_BITS + 2;
   localparam int SUM_B        = $clog2(MAX_LIVE + 1) + 1;
   localparam int SUM_BITS     = (SUM_A > SUM_B) ? SUM_A : SUM_B;
   localparam logic [31:0] HASH_MUL = 32'h9E3779B1;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_RESET  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_EMPTY = 2'd0,
      ST_LIVE  = 2'd1,
      ST_TOMB  = 2'd2
   } slot_status_type;

   typedef enum logic [1:0] {
      PK_FIND = 2'd0,
      PK_PUT  = 2'd1,
      PK_DROP = 2'd2
   } probe_kind_type;

   typedef struct packed {
      slot_status_type         status;
      logic [FRAME_BITS-1:0]   frame;
      logic [ZONE_ID_BITS-1:0] zone;
   } slot_word_type;

   typedef enum logic [3:0] {
      S_BOOT,
      S_IDLE,
      S_CLEAR,
      S_CHECK1,
      S_SWCLR,
      S_SWRD,
      S_SWEV,
      S_SPRD,
      S_SPEV,
      S_CHECK2,
      S_PAGE,
      S_PRD,
      S_PEV,
      S_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic           load_item;
      logic           clr_all_start;
      logic           clr_bank_start;
      logic           clr_step;
      logic           sw_start;
      logic           sw_read;
      logic           sw_next;
      logic           probe_init;
      logic           init_from_sweep;
      logic           probe_read;
      logic           probe_eval;
      probe_kind_type kind;
      logic           page_next;
      logic           set_disabled;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     disabled;
      logic     clr_last;
      logic     sw_last;
      logic     sw_live;
      logic     need_sweep;
      logic     over_limit;
      logic     pages_done;
      logic     pr_done;
      logic     pr_fail;
   } dp_status_type;

   function automatic logic [SLOT_BITS-1:0] hash_slot(input logic [FRAME_BITS-1:0] frame);
      logic [2*SLOT_BITS-1:0] prod;
      prod = (2*SLOT_BITS)'(frame[SLOT_BITS-1:0]) * (2*SLOT_BITS)'(HASH_MUL[SLOT_BITS-1:0]);
      return prod[SLOT_BITS-1:0];
   endfunction

endpackage

// ----- rtl/p2z_ram.sv -----
// p2z_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module p2z_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/p2z_dp.sv -----
// p2z_dp: datapath of the page to zone map: slot table, probe unit, counts
// depends on p2z_pkg and p2z_ram
module p2z_dp
   import p2z_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_status_type           stat,
   input  logic [MODE_BITS-1:0]    req_mode,
   input  logic [ADDR_BITS-1:0]    req_address,
   input  logic [PAGES_BITS-1:0]   req_page_count,
   input  logic [ZONE_ID_BITS-1:0] req_zone_id,
   input  logic                    csr_valid,
   input  logic [SHIFT_BITS-1:0]   csr_data,
   output logic                    rsp_found,
   output logic [ZONE_ID_BITS-1:0] rsp_found_zone,
   output logic                    rsp_active
);

   logic [SHIFT_BITS-1:0]    page_shift_ff, page_shift_in;
   mode_type                 mode_ff, mode_in;
   logic [PAGES_BITS-1:0]    pages_ff, pages_in;
   logic [PAGES_BITS-1:0]    page_idx_ff, page_idx_in;
   logic [ZONE_ID_BITS-1:0]  zone_ff, zone_in;
   logic [FRAME_BITS-1:0]    page_frame_ff, page_frame_in;
   logic [FRAME_BITS-1:0]    fmask_ff, fmask_in;
   logic [RAM_ADDR_BITS-1:0] clr_idx_ff, clr_idx_in;
   logic                     clr_all_ff, clr_all_in;
   logic [SLOT_BITS-1:0]     sw_idx_ff, sw_idx_in;
   logic [FRAME_BITS-1:0]    pf_ff, pf_in;
   logic [ZONE_ID_BITS-1:0]  pz_ff, pz_in;
   logic [SLOT_BITS-1:0]     slot_ff, slot_in;
   logic [SLOT_BITS-1:0]     cnt_ff, cnt_in;
   logic                     have_tomb_ff, have_tomb_in;
   logic [SLOT_BITS-1:0]     tomb_slot_ff, tomb_slot_in;
   logic [CNT_BITS-1:0]      live_ff, live_in;
   logic [CNT_BITS-1:0]      tomb_ff, tomb_in;
   logic                     disabled_ff, disabled_in;
   logic                     bank_ff, bank_in;
   logic                     found_ff, found_in;
   logic [ZONE_ID_BITS-1:0]  found_zone_ff, found_zone_in;

   logic                     wr_en, rd_en;
   logic [RAM_ADDR_BITS-1:0] wr_addr, rd_addr;
   slot_word_type            wr_word, rd_word;
   logic [SHIFT_BITS-1:0]    eff_shift;
   logic [ADDR_BITS-1:0]     addr_sh;
   logic [FRAME_BITS-1:0]    src_frame;
   logic                     is_match, cnt_last, tomb_avail, pr_done, pr_fail;
   logic [SLOT_BITS-1:0]     tomb_pick;

   p2z_ram #(
      .WIDTH ($bits(slot_word_type)),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   always_comb begin
      if (page_shift_ff < SHIFT_BITS'(MIN_SHIFT)) begin
         eff_shift = SHIFT_BITS'(MIN_SHIFT);
      end else if (page_shift_ff > SHIFT_BITS'(MAX_SHIFT)) begin
         eff_shift = SHIFT_BITS'(MAX_SHIFT);
      end else begin
         eff_shift = page_shift_ff;
      end
   end

   assign addr_sh    = req_address >> eff_shift;
   assign src_frame  = cmd.init_from_sweep ? rd_word.frame : page_frame_ff;
   assign is_match   = (rd_word.status == ST_LIVE) && (rd_word.frame == pf_ff);
   assign cnt_last   = (cnt_ff == {SLOT_BITS{1'b1}});
   assign tomb_avail = have_tomb_ff || (rd_word.status == ST_TOMB);
   assign tomb_pick  = have_tomb_ff ? tomb_slot_ff : slot_ff;

   // probe outcome for the slot word just read
   always_comb begin
      pr_done = 1'b0;
      pr_fail = 1'b0;
      case (cmd.kind)
         PK_FIND, PK_DROP: begin
            pr_done = (rd_word.status == ST_EMPTY) || is_match || cnt_last;
         end
         PK_PUT: begin
            pr_done = (rd_word.status == ST_EMPTY) || is_match || cnt_last;
            pr_fail = !is_match && (rd_word.status != ST_EMPTY) && cnt_last && !tomb_avail;
         end
         default: begin
            pr_done = 1'b1;
         end
      endcase
   end

   always_comb begin
      page_shift_in = page_shift_ff;
      mode_in       = mode_ff;
      pages_in      = pages_ff;
      page_idx_in   = page_idx_ff;
      zone_in       = zone_ff;
      page_frame_in = page_frame_ff;
      fmask_in      = fmask_ff;
      clr_idx_in    = clr_idx_ff;
      clr_all_in    = clr_all_ff;
      sw_idx_in     = sw_idx_ff;
      pf_in         = pf_ff;
      pz_in         = pz_ff;
      slot_in       = slot_ff;
      cnt_in        = cnt_ff;
      have_tomb_in  = have_tomb_ff;
      tomb_slot_in  = tomb_slot_ff;
      live_in       = live_ff;
      tomb_in       = tomb_ff;
      disabled_in   = disabled_ff;
      bank_in       = bank_ff;
      found_in      = found_ff;
      found_zone_in = found_zone_ff;
      wr_en         = 1'b0;
      wr_addr       = {bank_ff, slot_ff};
      wr_word       = '0;
      rd_en         = 1'b0;
      rd_addr       = {bank_ff, slot_ff};

      if (csr_valid) begin
         page_shift_in = csr_data;
      end

      if (cmd.load_item) begin
         mode_in       = mode_type'(req_mode);
         pages_in      = req_page_count;
         zone_in       = req_zone_id;
         page_frame_in = addr_sh[FRAME_BITS-1:0];
         fmask_in      = {FRAME_BITS{1'b1}} >> (eff_shift - SHIFT_BITS'(MIN_SHIFT));
         page_idx_in   = '0;
         found_in      = 1'b0;
         found_zone_in = '0;
      end

      if (cmd.clr_all_start) begin
         clr_idx_in  = '0;
         clr_all_in  = 1'b1;
         live_in     = '0;
         tomb_in     = '0;
         disabled_in = 1'b0;
         bank_in     = 1'b0;
      end

      if (cmd.clr_bank_start) begin
         clr_idx_in = '0;
         clr_all_in = 1'b0;
         bank_in    = !bank_ff;
         live_in    = '0;
         tomb_in    = '0;
      end

      if (cmd.clr_step) begin
         wr_en      = 1'b1;
         wr_addr    = clr_all_ff ? clr_idx_ff : {bank_ff, clr_idx_ff[SLOT_BITS-1:0]};
         wr_word    = '0;
         clr_idx_in = clr_idx_ff + 1'b1;
      end

      if (cmd.sw_start) begin
         sw_idx_in = '0;
      end
      if (cmd.sw_next) begin
         sw_idx_in = sw_idx_ff + 1'b1;
      end
      if (cmd.sw_read) begin
         rd_en   = 1'b1;
         rd_addr = {!bank_ff, sw_idx_ff};
      end

      if (cmd.probe_init) begin
         pf_in        = src_frame;
         pz_in        = cmd.init_from_sweep ? rd_word.zone : zone_ff;
         slot_in      = hash_slot(src_frame);
         cnt_in       = '0;
         have_tomb_in = 1'b0;
      end

      if (cmd.probe_read) begin
         rd_en   = 1'b1;
         rd_addr = {bank_ff, slot_ff};
      end

      if (cmd.probe_eval) begin
         if (!pr_done) begin
            slot_in = slot_ff + 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (rd_word.status == ST_TOMB && !have_tomb_ff) begin
               have_tomb_in = 1'b1;
               tomb_slot_in = slot_ff;
            end
         end
         case (cmd.kind)
            PK_FIND: begin
               if (is_match) begin
                  found_in      = 1'b1;
                  found_zone_in = rd_word.zone;
               end
            end
            PK_DROP: begin
               if (is_match) begin
                  wr_en          = 1'b1;
                  wr_addr        = {bank_ff, slot_ff};
                  wr_word.status = ST_TOMB;
                  wr_word.frame  = pf_ff;
                  wr_word.zone   = '0;
                  live_in        = live_ff - 1'b1;
                  tomb_in        = tomb_ff + 1'b1;
               end
            end
            PK_PUT: begin
               if (is_match) begin
                  wr_en          = 1'b1;
                  wr_addr        = {bank_ff, slot_ff};
                  wr_word.status = ST_LIVE;
                  wr_word.frame  = pf_ff;
                  wr_word.zone   = pz_ff;
               end else if (pr_done && !pr_fail) begin
                  // first tombstone seen wins over the empty slot
                  wr_en          = 1'b1;
                  wr_word.status = ST_LIVE;
                  wr_word.frame  = pf_ff;
                  wr_word.zone   = pz_ff;
                  live_in        = live_ff + 1'b1;
                  if (tomb_avail) begin
                     wr_addr = {bank_ff, tomb_pick};
                     tomb_in = tomb_ff - 1'b1;
                  end else begin
                     wr_addr = {bank_ff, slot_ff};
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.page_next) begin
         page_frame_in = (page_frame_ff + 1'b1) & fmask_ff;
         page_idx_in   = page_idx_ff + 1'b1;
      end

      if (cmd.set_disabled) begin
         disabled_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff <= SHIFT_BITS'(MIN_SHIFT);
         clr_idx_ff    <= '0;
         clr_all_ff    <= 1'b1;
         live_ff       <= '0;
         tomb_ff       <= '0;
         disabled_ff   <= 1'b0;
         bank_ff       <= 1'b0;
         found_ff      <= 1'b0;
         found_zone_ff <= '0;
         mode_ff       <= MODE_LOOKUP;
         page_idx_ff   <= '0;
         pages_ff      <= '0;
         sw_idx_ff     <= '0;
         cnt_ff        <= '0;
         have_tomb_ff  <= 1'b0;
      end else begin
         page_shift_ff <= page_shift_in;
         clr_idx_ff    <= clr_idx_in;
         clr_all_ff    <= clr_all_in;
         live_ff       <= live_in;
         tomb_ff       <= tomb_in;
         disabled_ff   <= disabled_in;
         bank_ff       <= bank_in;
         found_ff      <= found_in;
         found_zone_ff <= found_zone_in;
         mode_ff       <= mode_in;
         page_idx_ff   <= page_idx_in;
         pages_ff      <= pages_in;
         sw_idx_ff     <= sw_idx_in;
         cnt_ff        <= cnt_in;
         have_tomb_ff  <= have_tomb_in;
      end
   end

   always_ff @(posedge clock) begin
      zone_ff       <= zone_in;
      page_frame_ff <= page_frame_in;
      fmask_ff      <= fmask_in;
      pf_ff         <= pf_in;
      pz_ff         <= pz_in;
      slot_ff       <= slot_in;
      tomb_slot_ff  <= tomb_slot_in;
   end

   always_comb begin
      stat.mode       = mode_ff;
      stat.disabled   = disabled_ff;
      stat.clr_last   = clr_all_ff ? (clr_idx_ff == {RAM_ADDR_BITS{1'b1}})
                                   : (clr_idx_ff[SLOT_BITS-1:0] == {SLOT_BITS{1'b1}});
      stat.sw_last    = (sw_idx_ff == {SLOT_BITS{1'b1}});
      stat.sw_live    = (rd_word.status == ST_LIVE);
      stat.need_sweep = (SUM_BITS'(live_ff) + SUM_BITS'(tomb_ff) + SUM_BITS'(pages_ff))
                        > SUM_BITS'(MAX_LIVE);
      stat.over_limit = (SUM_BITS'(live_ff) + SUM_BITS'(pages_ff)) > SUM_BITS'(MAX_LIVE);
      stat.pages_done = (page_idx_ff == pages_ff);
      stat.pr_done    = pr_done;
      stat.pr_fail    = pr_fail;
   end

   assign rsp_found      = found_ff;
   assign rsp_found_zone = found_zone_ff;
   assign rsp_active     = !disabled_ff;

endmodule

// ----- rtl/p2z_ctrl.sv -----
// p2z_ctrl: controller state machine of the page to zone map
// depends on p2z_pkg
module p2z_ctrl
   import p2z_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MODE_BITS-1:0] req_mode,
   input  dp_status_type        stat,
   output dp_cmd_type           cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   ctrl_state_type state_ff, state_in;
   probe_kind_type item_kind;

   always_comb begin
      case (stat.mode)
         MODE_INSERT: item_kind = PK_PUT;
         MODE_REMOVE: item_kind = PK_DROP;
         default:     item_kind = PK_FIND;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_BOOT: begin
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               case (mode_type'(req_mode))
                  MODE_INSERT: state_in = S_CHECK1;
                  MODE_RESET:  state_in = S_CLEAR;
                  default:     state_in = S_PAGE;
               endcase
            end
         end
         S_CLEAR: begin
            if (stat.clr_last) state_in = S_RESP;
         end
         S_CHECK1: begin
            if (stat.disabled) begin
               state_in = S_RESP;
            end else if (stat.need_sweep) begin
               state_in = S_SWCLR;
            end else begin
               state_in = S_CHECK2;
            end
         end
         S_SWCLR: begin
            if (stat.clr_last) state_in = S_SWRD;
         end
         S_SWRD: state_in = S_SWEV;
         S_SWEV: begin
            if (stat.sw_live) begin
               state_in = S_SPRD;
            end else if (stat.sw_last) begin
               state_in = S_CHECK2;
            end else begin
               state_in = S_SWRD;
            end
         end
         S_SPRD: state_in = S_SPEV;
         S_SPEV: begin
            if (!stat.pr_done) begin
               state_in = S_SPRD;
            end else if (stat.sw_last) begin
               state_in = S_CHECK2;
            end else begin
               state_in = S_SWRD;
            end
         end
         S_CHECK2: begin
            state_in = stat.over_limit ? S_RESP : S_PAGE;
         end
         S_PAGE: begin
            if (stat.mode != MODE_LOOKUP && stat.pages_done) begin
               state_in = S_RESP;
            end else begin
               state_in = S_PRD;
            end
         end
         S_PRD: state_in = S_PEV;
         S_PEV: begin
            if (!stat.pr_done) begin
               state_in = S_PRD;
            end else if (stat.mode == MODE_LOOKUP || stat.pr_fail) begin
               state_in = S_RESP;
            end else begin
               state_in = S_PAGE;
            end
         end
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = (state_ff != S_IDLE);
      rsp_valid = 1'b0;
      case (state_ff)
         S_BOOT, S_CLEAR, S_SWCLR: begin
            cmd.clr_step = 1'b1;
            if (state_ff == S_SWCLR && stat.clr_last) cmd.sw_start = 1'b1;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_item = 1'b1;
               if (mode_type'(req_mode) == MODE_RESET) cmd.clr_all_start = 1'b1;
            end
         end
         S_CHECK1: begin
            if (!stat.disabled && stat.need_sweep) cmd.clr_bank_start = 1'b1;
         end
         S_SWRD: cmd.sw_read = 1'b1;
         S_SWEV: begin
            if (stat.sw_live) begin
               cmd.probe_init      = 1'b1;
               cmd.init_from_sweep = 1'b1;
            end else if (!stat.sw_last) begin
               cmd.sw_next = 1'b1;
            end
         end
         S_SPRD: begin
            cmd.probe_read = 1'b1;
            cmd.kind       = PK_PUT;
         end
         S_SPEV: begin
            cmd.probe_eval = 1'b1;
            cmd.kind       = PK_PUT;
            if (stat.pr_done && !stat.sw_last) cmd.sw_next = 1'b1;
         end
         S_CHECK2: begin
            if (stat.over_limit) cmd.set_disabled = 1'b1;
         end
         S_PAGE: begin
            if (!(stat.mode != MODE_LOOKUP && stat.pages_done)) cmd.probe_init = 1'b1;
         end
         S_PRD: begin
            cmd.probe_read = 1'b1;
            cmd.kind       = item_kind;
         end
         S_PEV: begin
            cmd.probe_eval = 1'b1;
            cmd.kind       = item_kind;
            if (stat.pr_done) begin
               if (stat.pr_fail) begin
                  cmd.set_disabled = 1'b1;
               end else if (stat.mode != MODE_LOOKUP) begin
                  cmd.page_next = 1'b1;
               end
            end
         end
         S_RESP: rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BOOT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/page_to_zone_hash_map.sv -----
// page_to_zone_hash_map: open addressed page frame to zone id table, linear probing;
// a probe is a read state and then a compare state, and every item ends with the rsp_valid strobe:
//   lookup probes one page, remove probes each of its pages, insert probes each page after its
//   checks (none when over the limit or while disabled); reset map clears both banks
// an insert sweep clears the other bank, reads every slot and probes again for each live entry
// after reset busy stays high while both banks clear; one item at a time, no rsp stall
module page_to_zone_hash_map
   import p2z_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [MODE_BITS-1:0]    req_mode,
   input  logic [ADDR_BITS-1:0]    req_address,
   input  logic [PAGES_BITS-1:0]   req_page_count,
   input  logic [ZONE_ID_BITS-1:0] req_zone_id,
   output logic                    rsp_valid,
   output logic                    rsp_found,
   output logic [ZONE_ID_BITS-1:0] rsp_found_zone,
   output logic                    rsp_active,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [SHIFT_BITS-1:0]   csr_data
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   assign csr_ready = 1'b1;

   p2z_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   p2z_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_mode       (req_mode),
      .req_address    (req_address),
      .req_page_count (req_page_count),
      .req_zone_id    (req_zone_id),
      .csr_valid      (csr_valid && csr_ready),
      .csr_data       (csr_data),
      .rsp_found      (rsp_found),
      .rsp_found_zone (rsp_found_zone),
      .rsp_active     (rsp_active)
   );

endmodule

// ----- test/tb.sv -----
// tb: self-checking testbench for page_to_zone_hash_map, with a behavioral copy of the page map
// depends on rtl/p2z_pkg.sv and rtl/page_to_zone_hash_map.sv
`timescale 1ns / 100ps

module tb;
   import p2z_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000000;
   localparam logic [ADDR_BITS-1:0] ADDR_ONES = '1;

   typedef struct packed {
      logic                    found;
      logic [ZONE_ID_BITS-1:0] zone;
      logic                    active;
   } lookup_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [MODE_BITS-1:0]    req_mode = MODE_LOOKUP;
   logic [ADDR_BITS-1:0]    req_address = '0;
   logic [PAGES_BITS-1:0]   req_page_count = '0;
   logic [ZONE_ID_BITS-1:0] req_zone_id = '0;
   logic                    rsp_valid;
   logic                    rsp_found;
   logic [ZONE_ID_BITS-1:0] rsp_found_zone;
   logic                    rsp_active;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [SHIFT_BITS-1:0]   csr_data = '0;

   page_to_zone_hash_map dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_address(req_address), .req_page_count(req_page_count),
      .req_zone_id(req_zone_id), .rsp_valid(rsp_valid), .rsp_found(rsp_found),
      .rsp_found_zone(rsp_found_zone), .rsp_active(rsp_active),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // behavioral page map
   slot_status_type         map_status [2][TABLE_SLOTS];
   logic [ADDR_BITS-1:0]    map_frame  [2][TABLE_SLOTS];
   logic [ZONE_ID_BITS-1:0] map_zone   [2][TABLE_SLOTS];
   int unsigned             live_pages;
   int unsigned             tomb_pages;
   bit                      map_off;
   int unsigned             bank;
   logic [SHIFT_BITS-1:0]   page_shift_reg;

   lookup_result_type       pending_results[$];
   logic [ADDR_BITS-1:0]    zone_bases[$];
   int unsigned             error_count = 0;
   int unsigned             items_sent = 0;
   int unsigned             hits_seen = 0;
   int unsigned             sweeps_done = 0;
   int unsigned             burst_left = 0;
   bit                      bursty = 1'b1;

   function automatic int unsigned slot_of(logic [ADDR_BITS-1:0] fr);
      logic [63:0] prod;
      prod = 64'(fr) * 64'd2654435761;
      return int'(prod[SLOT_BITS-1:0]);
   endfunction

   function automatic void clear_pages();
      for (int b = 0; b < 2; b++)
         for (int s = 0; s < TABLE_SLOTS; s++) map_status[b][s] = ST_EMPTY;
      live_pages = 0;
      tomb_pages = 0;
      map_off = 1'b0;
      bank = 0;
   endfunction

   function automatic bit place_page(logic [ADDR_BITS-1:0] fr, logic [ZONE_ID_BITS-1:0] zn);
      int unsigned s;
      int unsigned probes;
      int unsigned tomb_slot;
      bit          have_tomb;
      s = slot_of(fr);
      probes = 0;
      tomb_slot = 0;
      have_tomb = 0;
      while (probes < TABLE_SLOTS) begin
         if (map_status[bank][s] == ST_EMPTY) break;
         if (map_status[bank][s] == ST_LIVE && map_frame[bank][s] == fr) begin
            map_zone[bank][s] = zn;
            return 1;
         end
         if (map_status[bank][s] == ST_TOMB && !have_tomb) begin
            tomb_slot = s;
            have_tomb = 1;
         end
         s = (s + 1) % TABLE_SLOTS;
         probes++;
      end
      if (have_tomb) begin
         s = tomb_slot;
         tomb_pages--;
      end else if (probes == TABLE_SLOTS) begin
         return 0;
      end
      live_pages++;
      map_status[bank][s] = ST_LIVE;
      map_frame[bank][s] = fr;
      map_zone[bank][s] = zn;
      return 1;
   endfunction

   function automatic void drop_page(logic [ADDR_BITS-1:0] fr);
      int unsigned s;
      s = slot_of(fr);
      for (int p = 0; p < TABLE_SLOTS; p++) begin
         if (map_status[bank][s] == ST_EMPTY) return;
         if (map_status[bank][s] == ST_LIVE && map_frame[bank][s] == fr) begin
            map_status[bank][s] = ST_TOMB;
            map_zone[bank][s] = '0;
            live_pages--;
            tomb_pages++;
            return;
         end
         s = (s + 1) % TABLE_SLOTS;
      end
   endfunction

   function automatic bit find_page(logic [ADDR_BITS-1:0] fr,
                                    output logic [ZONE_ID_BITS-1:0] zn);
      int unsigned s;
      s = slot_of(fr);
      zn = '0;
      for (int p = 0; p < TABLE_SLOTS; p++) begin
         if (map_status[bank][s] == ST_EMPTY) return 0;
         if (map_status[bank][s] == ST_LIVE && map_frame[bank][s] == fr) begin
            zn = map_zone[bank][s];
            return 1;
         end
         s = (s + 1) % TABLE_SLOTS;
      end
      return 0;
   endfunction

   // live entries move to the other bank, tombstones vanish
   function automatic void sweep_bank();
      int unsigned old_bank;
      old_bank = bank;
      bank = old_bank ^ 1;
      for (int s = 0; s < TABLE_SLOTS; s++) map_status[bank][s] = ST_EMPTY;
      live_pages = 0;
      tomb_pages = 0;
      for (int s = 0; s < TABLE_SLOTS; s++)
         if (map_status[old_bank][s] == ST_LIVE)
            void'(place_page(map_frame[old_bank][s], map_zone[old_bank][s]));
      sweeps_done++;
   endfunction

   function automatic lookup_result_type apply_request(mode_type md, logic [ADDR_BITS-1:0] addr,
                                                       logic [PAGES_BITS-1:0] pages,
                                                       logic [ZONE_ID_BITS-1:0] zn);
      lookup_result_type    r;
      int unsigned          sh;
      logic [ADDR_BITS-1:0] fmask;
      logic [ADDR_BITS-1:0] base;
      sh = (page_shift_reg < MIN_SHIFT) ? MIN_SHIFT :
           (page_shift_reg > MAX_SHIFT) ? MAX_SHIFT : page_shift_reg;
      fmask = ADDR_ONES >> sh;
      base = addr >> sh;
      r = '0;
      case (md)
         MODE_LOOKUP: begin
            r.found = find_page(base, r.zone);
         end
         MODE_INSERT: begin
            if (!map_off) begin
               if (live_pages + tomb_pages + pages > MAX_LIVE) sweep_bank();
               if (live_pages + pages > MAX_LIVE) begin
                  map_off = 1'b1;
               end else begin
                  for (int i = 0; i < pages; i++)
                     if (!place_page((base + i) & fmask, zn)) begin
                        map_off = 1'b1;
                        break;
                     end
               end
            end
         end
         MODE_REMOVE: begin
            for (int i = 0; i < pages; i++) drop_page((base + i) & fmask);
         end
         default: clear_pages();
      endcase
      r.active = !map_off;
      return r;
   endfunction

   // sender: the caller is at a rising edge; start stays high for back to back items
   task automatic send_item(mode_type md, logic [ADDR_BITS-1:0] addr,
                            logic [PAGES_BITS-1:0] pages, logic [ZONE_ID_BITS-1:0] zn);
      int unsigned gap;
      if (bursty && burst_left == 0) begin
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 25);
      end
      start <= 1'b1;
      req_mode <= md;
      req_address <= addr;
      req_page_count <= pages;
      req_zone_id <= zn;
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_request(md, addr, pages, zn));
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (md == MODE_INSERT && pages != 0) begin
         zone_bases.push_back(addr);
         if (zone_bases.size() > 48) void'(zone_bases.pop_front());
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_page_shift(logic [SHIFT_BITS-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      page_shift_reg = value;
   endtask

   // result checker; the receiver cannot stall
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result found=%0b zone=%h active=%0b", $time,
                     rsp_found, rsp_found_zone, rsp_active);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_found) hits_seen++;
            if (rsp_found !== want.found) begin
               $display("%0t: found expected %0b actual %0b", $time, want.found, rsp_found);
               error_count++;
            end
            if (rsp_found_zone !== want.zone) begin
               $display("%0t: found_zone expected %h actual %h", $time, want.zone,
                        rsp_found_zone);
               error_count++;
            end
            if (rsp_active !== want.active) begin
               $display("%0t: active expected %0b actual %0b", $time, want.active, rsp_active);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction
   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic test_empty_and_basic();
      send_item(MODE_LOOKUP, '0, '0, '0);
      send_item(MODE_LOOKUP, ADDR_ONES, '1, '1);
      send_item(MODE_INSERT, '0, 13'd1, 16'hFFFF);
      send_item(MODE_LOOKUP, 48'h0000_0000_0FFF, '0, '0);
      send_item(MODE_INSERT, 48'h1234_5678_9ABC, 13'd4, 16'h0000);
      send_item(MODE_LOOKUP, 48'h1234_5678_B000, '0, '0);
      send_item(MODE_INSERT, 48'h1234_5678_A000, 13'd1, 16'hA5A5);
      send_item(MODE_LOOKUP, 48'h1234_5678_A123, '0, '0);
   endtask

   task automatic test_wrap_and_remove();
      // last frame of the space wraps back to frame zero
      send_item(MODE_INSERT, 48'hFFFF_FFFF_F000, 13'd3, 16'h5A5A);
      send_item(MODE_LOOKUP, 48'h0000_0000_1000, '0, '0);
      send_item(MODE_INSERT, 48'h0, 13'd0, 16'h1111);
      send_item(MODE_REMOVE, 48'h0, 13'd0, '0);
      send_item(MODE_REMOVE, 48'h7777_0000_0000, 13'd2, '0);
      send_item(MODE_REMOVE, 48'hFFFF_FFFF_F000, 13'd2, '0);
      send_item(MODE_LOOKUP, 48'h0, '0, '0);
      send_item(MODE_LOOKUP, 48'h0000_0000_1000, '0, '0);
      send_item(MODE_REMOVE, 48'h8000_0000_0000, 13'h1FFF, '0);
   endtask

   task automatic test_sweep_and_disable();
      send_item(MODE_INSERT, 48'h0010_0000_0000, 13'd2000, 16'h0101);
      send_item(MODE_REMOVE, 48'h0010_0000_0000, 13'd1000, '0);
      // live plus tombstones overflow, sweep makes room
      send_item(MODE_INSERT, 48'h0020_0000_0000, 13'd1500, 16'h0202);
      send_item(MODE_LOOKUP, 48'h0010_0000_0000 + 48'd1500 * 48'h1000, '0, '0);
      send_item(MODE_INSERT, 48'h0030_0000_0000, 13'h1FFF, 16'h0303);
      send_item(MODE_INSERT, 48'h0040_0000_0000, 13'd1, 16'h0404);
      send_item(MODE_LOOKUP, 48'h0020_0000_0000, '0, '0);
      send_item(MODE_REMOVE, 48'h0020_0000_0000, 13'd4, '0);
      send_item(MODE_RESET, ADDR_ONES, '1, '1);
      send_item(MODE_LOOKUP, 48'h0020_0000_5000, '0, '0);
      send_item(MODE_INSERT, 48'h0050_0000_0000, 13'd3072, 16'h0505);
      send_item(MODE_INSERT, 48'h0060_0000_0000, 13'd1, 16'h0606);
      send_item(MODE_RESET, '0, '0, '0);
   endtask

   task automatic test_random_traffic(int unsigned count);
      int unsigned          pick;
      logic [ADDR_BITS-1:0] addr;
      logic [PAGES_BITS-1:0] pages;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         addr = ADDR_BITS'({$urandom, $urandom});
         if (zone_bases.size() != 0 && $urandom_range(0, 3) != 0)
            addr = zone_bases[$urandom_range(0, zone_bases.size() - 1)]
                   + ($urandom_range(0, 9) << 12) + $urandom_range(0, 16'hFFFF);
         pages = PAGES_BITS'($urandom_range(0, 9) == 0 ? $urandom_range(0, 40)
                                                        : $urandom_range(1, 6));
         if ($urandom_range(0, 149) == 0) pages = PAGES_BITS'($urandom);
         if (pick < 45)
            send_item(MODE_LOOKUP, addr, PAGES_BITS'($urandom), ZONE_ID_BITS'($urandom));
         else if (pick < 78) send_item(MODE_INSERT, addr, pages, ZONE_ID_BITS'($urandom));
         else if (pick < 97) send_item(MODE_REMOVE, addr, pages, ZONE_ID_BITS'($urandom));
         else send_item(MODE_RESET, addr, PAGES_BITS'($urandom), ZONE_ID_BITS'($urandom));
      end
   endtask

   initial begin
      clear_pages();
      page_shift_reg = 5'(MIN_SHIFT);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_basic();
      test_wrap_and_remove();
      test_sweep_and_disable();
      write_page_shift(5'd16);
      test_random_traffic(280);
      write_page_shift(5'd0);
      bursty = 1'b0;
      test_random_traffic(280);
      bursty = 1'b1;
      write_page_shift(5'd31);
      test_random_traffic(280);
      write_page_shift(5'd12);
      test_random_traffic(280);
      write_page_shift(SHIFT_BITS'($urandom));
      test_random_traffic(250);
      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d items, %0d lookup hits, %0d bank sweeps", items_sent, hits_seen,
               sweeps_done);
      $display("page shifts 12, 16, saturated low and high, and one random setting");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d results missing", error_count, pending_results.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/p2z_pkg.sv
rtl/p2z_ram.sv
rtl/p2z_dp.sv
rtl/p2z_ctrl.sv
rtl/page_to_zone_hash_map.sv
test/tb.sv
